/* hw/rtl/relative_pose_2d_residual_unit_assert.svh */
// ----------------------------------------------------------------------------
// relative pose residual unit: assertion macros
// shared concurrent checks, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef RELATIVE_POSE_2D_RESIDUAL_UNIT_ASSERT_SVH
`define RELATIVE_POSE_2D_RESIDUAL_UNIT_ASSERT_SVH

// same-cycle implication
`define RP2R_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rp2r check failed");

// next-cycle implication
`define RP2R_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rp2r check failed");

`endif

/* hw/rtl/rp2r_pkg.sv */
// ----------------------------------------------------------------------------
// rp2r_pkg
// types and constants of the relative pose residual unit
// ----------------------------------------------------------------------------
package rp2r_pkg;

  typedef logic signed [31:0] pos_t;
  typedef logic signed [15:0] ang_t;
  typedef logic signed [16:0] relh_t;
  typedef logic signed [15:0] trig_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [28:0] zwide_t;
  typedef logic signed [27:0] zang_t;
  typedef logic signed [31:0] cxy_t;
  typedef logic signed [48:0] prod_t;
  typedef logic signed [49:0] psum_t;
  typedef logic signed [35:0] rnd_t;

  typedef struct packed {
    logic  present;
    logic  flip;
    diff_t dx;
    diff_t dy;
    relh_t relh;
  } side_t;

  localparam int ATAN_ENTRIES = 24;

  localparam logic [23:0] ATAN_Q24 [ATAN_ENTRIES] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
    24'd1047214,  24'd524117,  24'd262123,  24'd131069,
    24'd65536,    24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,
    24'd256,      24'd128,     24'd64,      24'd32,
    24'd16,       24'd8,       24'd4,       24'd2
  };

  localparam zwide_t HALF_PI_Q24 = 29'sd26353589;
  localparam zwide_t PI_Q24      = 29'sd52707179;
  localparam zwide_t PI2_Q24     = 29'sd105414358;
  localparam zwide_t PI3_Q24     = 29'sd158121537;
  localparam zwide_t FOLD_T1     = 29'sd79060768;
  localparam zwide_t FOLD_T2     = 29'sd131767947;

  localparam cxy_t  GAIN_Q28   = 32'sd163008219;
  localparam cxy_t  Q14_HALF   = 32'sd8192;
  localparam cxy_t  Q14_ONE    = 32'sd16384;
  localparam psum_t SUM_HALF   = 50'sd8192;
  localparam pos_t  POS_MAX    = 32'sh7fffffff;
  localparam pos_t  POS_MIN    = 32'sh80000000;
  localparam rnd_t  RND_MAX    = 36'sh07fffffff;
  localparam rnd_t  RND_MIN    = 36'shf80000000;

endpackage

/* hw/rtl/rp2r_if.sv */
// ----------------------------------------------------------------------------
// rp2r channel interfaces
// valid/ready channels for pose pairs in and residual results out
// ----------------------------------------------------------------------------
interface rp2r_in_if
  import rp2r_pkg::*;
();
  logic valid;
  logic ready;
  logic ref_present;
  pos_t ref_x;
  pos_t ref_y;
  ang_t ref_heading;
  pos_t tgt_x;
  pos_t tgt_y;
  ang_t tgt_heading;

  modport source (
    output valid, ref_present, ref_x, ref_y, ref_heading, tgt_x, tgt_y, tgt_heading,
    input  ready
  );
  modport sink (
    input  valid, ref_present, ref_x, ref_y, ref_heading, tgt_x, tgt_y, tgt_heading,
    output ready
  );
endinterface

interface rp2r_out_if
  import rp2r_pkg::*;
();
  logic  valid;
  logic  ready;
  pos_t  rel_x;
  pos_t  rel_y;
  relh_t rel_heading;
  trig_t cos_ref;
  trig_t sin_ref;
  pos_t  drelx_dheading;
  pos_t  drely_dheading;

  modport source (
    output valid, rel_x, rel_y, rel_heading, cos_ref, sin_ref, drelx_dheading,
           drely_dheading,
    input  ready
  );
  modport sink (
    input  valid, rel_x, rel_y, rel_heading, cos_ref, sin_ref, drelx_dheading,
           drely_dheading,
    output ready
  );
endinterface

/* hw/rtl/relative_pose_2d_residual_unit.sv */
// ----------------------------------------------------------------------------
// relative_pose_2d_residual_unit
// rotates target offset into the reference frame with a pipelined cordic,
// outputs relative pose, cos/sin of reference heading and heading partials
//
//   channel  dir  beat
//   in_ch    in   reference pose, target pose, presence flag
//   out_ch   out  relative pose, cos/sin, two heading partials
//
// one beat per cycle sustained while out_ch.ready is high
// stages: heading fold, one per cordic iteration, q1.14 round, multiply,
// sum and round, saturate
// synchronous active-low reset clears the stage valid bits only
// a stalled output holds its beat; empty stages still fill, so in_ch.ready
// drops only when every stage holds a beat and the output is blocked
// ----------------------------------------------------------------------------
`include "relative_pose_2d_residual_unit_assert.svh"

module relative_pose_2d_residual_unit
  import rp2r_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  rp2r_in_if.sink       in_ch,
  rp2r_out_if.source    out_ch
);

  localparam int ST_TRIG = CORDIC_STAGES + 1;
  localparam int ST_MUL  = CORDIC_STAGES + 2;
  localparam int ST_SUM  = CORDIC_STAGES + 3;
  localparam int ST_OUT  = CORDIC_STAGES + 4;
  localparam int NUM_ST  = CORDIC_STAGES + 5;

  logic [NUM_ST-1:0] valid_r;
  logic [NUM_ST-1:0] valid_nxt;
  logic [NUM_ST-1:0] stage_en;

  side_t side_r [NUM_ST];
  cxy_t  x_r [CORDIC_STAGES+1];
  cxy_t  y_r [CORDIC_STAGES+1];
  zang_t z_r [CORDIC_STAGES+1];

  // stall chain: a stage moves when empty or when the next one moves
  assign stage_en[NUM_ST-1] = !valid_r[NUM_ST-1] || out_ch.ready;
  for (genvar k = 0; k < NUM_ST - 1; k++) begin : g_en
    assign stage_en[k] = !valid_r[k] || stage_en[k+1];
  end

  assign in_ch.ready = stage_en[0];

  always_comb begin
    valid_nxt[0] = stage_en[0] ? in_ch.valid : valid_r[0];
    for (int k = 1; k < NUM_ST; k++) begin
      valid_nxt[k] = stage_en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stage 0: operand select, differences, heading fold into [-pi/2, pi/2]
  pos_t   ref_x_eff;
  pos_t   ref_y_eff;
  ang_t   ref_h_eff;
  zwide_t z_in;
  zwide_t z_fold;
  zwide_t kpi;
  logic [1:0] n_pos;
  logic [1:0] n_neg;
  logic [1:0] n_sel;
  side_t  side_in;

  always_comb begin
    ref_x_eff = in_ch.ref_present ? in_ch.ref_x : '0;
    ref_y_eff = in_ch.ref_present ? in_ch.ref_y : '0;
    ref_h_eff = in_ch.ref_present ? in_ch.ref_heading : '0;
    z_in  = {ref_h_eff[15], ref_h_eff, 12'b0};
    n_pos = 2'(z_in > HALF_PI_Q24) + 2'(z_in > FOLD_T1) + 2'(z_in > FOLD_T2);
    n_neg = 2'(z_in < -HALF_PI_Q24) + 2'(z_in < -FOLD_T1) + 2'(z_in < -FOLD_T2);
    n_sel = (n_pos != 2'd0) ? n_pos : n_neg;
    case (n_sel)
      2'd0:    kpi = '0;
      2'd1:    kpi = PI_Q24;
      2'd2:    kpi = PI2_Q24;
      default: kpi = PI3_Q24;
    endcase
    z_fold = (n_pos != 2'd0) ? (z_in - kpi) : (z_in + kpi);
    side_in.present = in_ch.ref_present;
    side_in.flip    = n_sel[0];
    side_in.dx      = 33'(in_ch.tgt_x) - 33'(ref_x_eff);
    side_in.dy      = 33'(in_ch.tgt_y) - 33'(ref_y_eff);
    side_in.relh    = 17'(in_ch.tgt_heading) - 17'(ref_h_eff);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      side_r[0] <= side_in;
      x_r[0]    <= GAIN_Q28;
      y_r[0]    <= '0;
      z_r[0]    <= z_fold[27:0];
    end
  end

  // cordic iterations, rotation mode
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    localparam zang_t ATAN_K = zang_t'(ATAN_Q24[k]);
    always_ff @(posedge clk) begin
      if (stage_en[k+1]) begin
        side_r[k+1] <= side_r[k];
        if (z_r[k] >= 0) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - ATAN_K;
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + ATAN_K;
        end
      end
    end
  end

  // round to q1.14, clamp, apply fold sign
  function automatic trig_t to_q14(input cxy_t v, input logic flip);
    cxy_t r;
    r = (v + Q14_HALF) >>> 14;
    if (r > Q14_ONE) r = Q14_ONE;
    if (r < -Q14_ONE) r = -Q14_ONE;
    if (flip) r = -r;
    return r[15:0];
  endfunction

  trig_t cos_t_r, sin_t_r;
  trig_t cos_m_r, sin_m_r;
  trig_t cos_a_r, sin_a_r;
  trig_t cos_o_r, sin_o_r;

  always_ff @(posedge clk) begin
    if (stage_en[ST_TRIG]) begin
      side_r[ST_TRIG] <= side_r[CORDIC_STAGES];
      cos_t_r <= to_q14(x_r[CORDIC_STAGES], side_r[CORDIC_STAGES].flip);
      sin_t_r <= to_q14(y_r[CORDIC_STAGES], side_r[CORDIC_STAGES].flip);
    end
  end

  // products
  prod_t prod_xc_r, prod_ys_r, prod_yc_r, prod_xs_r;

  always_ff @(posedge clk) begin
    if (stage_en[ST_MUL]) begin
      side_r[ST_MUL] <= side_r[ST_TRIG];
      cos_m_r   <= cos_t_r;
      sin_m_r   <= sin_t_r;
      prod_xc_r <= side_r[ST_TRIG].dx * cos_t_r;
      prod_ys_r <= side_r[ST_TRIG].dy * sin_t_r;
      prod_yc_r <= side_r[ST_TRIG].dy * cos_t_r;
      prod_xs_r <= side_r[ST_TRIG].dx * sin_t_r;
    end
  end

  // sums, rounded to q16.16
  psum_t sum_x;
  psum_t sum_y;
  rnd_t  rx_r, ry_r;

  always_comb begin
    sum_x = 50'(prod_xc_r) + 50'(prod_ys_r) + SUM_HALF;
    sum_y = 50'(prod_yc_r) - 50'(prod_xs_r) + SUM_HALF;
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_SUM]) begin
      side_r[ST_SUM] <= side_r[ST_MUL];
      cos_a_r <= cos_m_r;
      sin_a_r <= sin_m_r;
      rx_r    <= sum_x[49:14];
      ry_r    <= sum_y[49:14];
    end
  end

  // saturation and partials
  pos_t rel_x_sat;
  pos_t rel_y_sat;
  pos_t px_nxt;
  pos_t py_nxt;
  pos_t rel_x_r, rel_y_r, px_r, py_r;
  relh_t relh_r;

  always_comb begin
    if (rx_r > RND_MAX) rel_x_sat = POS_MAX;
    else if (rx_r < RND_MIN) rel_x_sat = POS_MIN;
    else rel_x_sat = rx_r[31:0];
    if (ry_r > RND_MAX) rel_y_sat = POS_MAX;
    else if (ry_r < RND_MIN) rel_y_sat = POS_MIN;
    else rel_y_sat = ry_r[31:0];
    if (side_r[ST_SUM].present) begin
      px_nxt = rel_y_sat;
      py_nxt = (rel_x_sat == POS_MIN) ? POS_MAX : -rel_x_sat;
    end else begin
      px_nxt = '0;
      py_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_OUT]) begin
      side_r[ST_OUT] <= side_r[ST_SUM];
      cos_o_r <= cos_a_r;
      sin_o_r <= sin_a_r;
      rel_x_r <= rel_x_sat;
      rel_y_r <= rel_y_sat;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      relh_r  <= side_r[ST_SUM].relh;
    end
  end

  assign out_ch.valid          = valid_r[ST_OUT];
  assign out_ch.rel_x          = rel_x_r;
  assign out_ch.rel_y          = rel_y_r;
  assign out_ch.rel_heading    = relh_r;
  assign out_ch.cos_ref        = cos_o_r;
  assign out_ch.sin_ref        = sin_o_r;
  assign out_ch.drelx_dheading = px_r;
  assign out_ch.drely_dheading = py_r;

  `RP2R_ASSERT_HOLDS(a_trig_range, out_ch.valid, (out_ch.cos_ref <= 16'sd16384) && (out_ch.cos_ref >= -16'sd16384) && (out_ch.sin_ref <= 16'sd16384) && (out_ch.sin_ref >= -16'sd16384))
  `RP2R_ASSERT_HOLDS(a_absent_partials, out_ch.valid && !side_r[ST_OUT].present, (out_ch.drelx_dheading == '0) && (out_ch.drely_dheading == '0))
  `RP2R_ASSERT_HOLDS(a_ready_bubble, out_ch.valid && !out_ch.ready, in_ch.ready == ($countones(valid_r) != NUM_ST))
  `RP2R_ASSERT_NEXT(a_sum_stage_hold, out_ch.valid && !out_ch.ready && valid_r[ST_SUM], valid_r[ST_SUM] && $stable(rx_r) && $stable(ry_r))

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// feeds pose pairs to relative_pose_2d_residual_unit and checks every residual
// beat, field by field, against a bit-exact model of the heading fold, the
// cordic, the rotation and the saturation; both channels idle at random and
// the source also pauses until the pipeline has drained
// ----------------------------------------------------------------------------
module tb;
  import rp2r_pkg::*;

  localparam int STAGES       = 16;
  localparam int DRAIN_CYCLES = STAGES + 25;
  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_BEATS = 1550;
  localparam int MAX_REPORTS  = 10;
  localparam int MAX_WAIT     = 17;
  localparam int DIRECTED_ROWS = 25;

  localparam longint FOLD_PI      = 64'sd52707179;
  localparam longint FOLD_HALF_PI = 64'sd26353589;
  localparam longint CORDIC_GAIN  = 64'sd163008219;
  localparam longint ARCTAN [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  localparam pos_t PMAX = 32'sh7fffffff;
  localparam pos_t PMIN = 32'sh80000000;
  localparam pos_t RX_A = 32'sh00008000;
  localparam pos_t RY_A = -32'sh00010000;
  localparam pos_t TX_A = 32'sh01234567;
  localparam pos_t TY_A = -32'sh07654321;

  typedef struct packed {
    logic ref_present;
    pos_t ref_x;
    pos_t ref_y;
    ang_t ref_heading;
    pos_t tgt_x;
    pos_t tgt_y;
    ang_t tgt_heading;
  } pose_pair_t;

  typedef struct packed {
    pos_t  rel_x;
    pos_t  rel_y;
    relh_t rel_heading;
    trig_t cos_ref;
    trig_t sin_ref;
    pos_t  drelx_dheading;
    pos_t  drely_dheading;
  } residual_t;

  // known_relh / known_part: heading difference / partials typed in the row
  typedef struct packed {
    logic  known_relh;
    logic  known_part;
    logic  present;
    pos_t  rx;
    pos_t  ry;
    ang_t  rh;
    pos_t  tx;
    pos_t  ty;
    ang_t  th;
    relh_t relh;
    pos_t  px;
    pos_t  py;
  } vector_row_t;

  localparam vector_row_t DIRECTED [DIRECTED_ROWS] = '{
    // reference absent
    '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 1, 0, PMAX, PMAX, 16'sd32767, 0, 0, 16'sd32767, 17'sd32767, 0, 0},
    '{1, 1, 0, PMIN, PMIN, 16'sh8000, 1, -1, 16'sh8000, -17'sd32768, 0, 0},
    '{1, 1, 0, 5, 5, 5, PMAX, PMIN, 0, 0, 0, 0},
    // heading difference extremes
    '{1, 0, 1, 0, 0, 16'sh8000, 100, 200, 16'sd32767, 17'sd65535, 0, 0},
    '{1, 0, 1, 0, 0, 16'sd32767, 0, 0, 16'sh8000, -17'sd65535, 0, 0},
    // position saturation, including negation of the most negative rel_x
    '{0, 0, 1, PMIN, 0, 0, PMAX, 0, 0, 0, 0, 0},
    '{0, 0, 1, PMAX, 0, 0, PMIN, 0, 0, 0, 0, 0},
    '{0, 0, 1, 0, PMIN, 0, 0, PMAX, 0, 0, 0, 0},
    '{0, 0, 1, 0, PMAX, 0, 0, PMIN, 0, 0, 0, 0},
    '{0, 0, 1, PMIN, PMIN, 16'sd3217, PMAX, PMAX, 0, 0, 0, 0},
    '{0, 0, 1, PMAX, PMAX, -16'sd9651, PMIN, PMIN, 0, 0, 0, 0},
    // headings on both sides of each positive fold threshold and of pi, and past each negative one
    '{0, 0, 1, RX_A, RY_A, 16'sd6433, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, 16'sd6434, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, -16'sd6433, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, -16'sd6434, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, 16'sd12867, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, 16'sd12868, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, -16'sd12868, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, 16'sd19301, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, 16'sd19302, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, -16'sd19302, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, 16'sd32169, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, 16'sd32170, TX_A, TY_A, 16'sd100, 0, 0, 0},
    '{0, 0, 1, RX_A, RY_A, -16'sd32170, TX_A, TY_A, 16'sd100, 0, 0, 0}
  };

  logic clk;
  logic rst_n;

  rp2r_in_if  pose_bus ();
  rp2r_out_if residual_bus ();

  residual_t pending_residuals [$];
  int        error_count;
  int        residual_beats;
  int        idle_cycles;

  relative_pose_2d_residual_unit #(
    .CORDIC_STAGES (STAGES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pose_bus),
    .out_ch (residual_bus)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint round_q14(input longint v);
    longint r;
    r = (v + 64'sd8192) >>> 14;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return r;
  endfunction

  function automatic longint sat_pos(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void heading_trig(input longint heading, output longint c,
                                       output longint s);
    longint z, x, y, nx;
    bit     flip;
    z = heading * 64'sd4096;
    x = CORDIC_GAIN;
    y = 0;
    flip = 1'b0;
    while (z > FOLD_HALF_PI) begin
      z -= FOLD_PI;
      flip = ~flip;
    end
    while (z < -FOLD_HALF_PI) begin
      z += FOLD_PI;
      flip = ~flip;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = nx;
    end
    c = round_q14(x);
    s = round_q14(y);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic residual_t predict_residual(input pose_pair_t p);
    longint    rx, ry, rh, dx, dy, c, s, relx, rely;
    residual_t r;
    rx = p.ref_present ? longint'(p.ref_x) : 64'sd0;
    ry = p.ref_present ? longint'(p.ref_y) : 64'sd0;
    rh = p.ref_present ? longint'(p.ref_heading) : 64'sd0;
    heading_trig(rh, c, s);
    dx = longint'(p.tgt_x) - rx;
    dy = longint'(p.tgt_y) - ry;
    relx = sat_pos((dx * c + dy * s + 64'sd8192) >>> 14);
    rely = sat_pos((dy * c - dx * s + 64'sd8192) >>> 14);
    r.rel_x          = pos_t'(relx);
    r.rel_y          = pos_t'(rely);
    r.rel_heading    = relh_t'(longint'(p.tgt_heading) - rh);
    r.cos_ref        = trig_t'(c);
    r.sin_ref        = trig_t'(s);
    r.drelx_dheading = p.ref_present ? pos_t'(rely) : pos_t'(0);
    r.drely_dheading = p.ref_present ? pos_t'(sat_pos(-relx)) : pos_t'(0);
    return r;
  endfunction

  function automatic pos_t edge_position();
    case ($urandom_range(0, 4))
      0: return PMIN;
      1: return PMAX;
      2: return pos_t'(0);
      3: return pos_t'(-1);
      default: return pos_t'($urandom);
    endcase
  endfunction

  function automatic ang_t fold_heading();
    ang_t base;
    case ($urandom_range(0, 3))
      0: base = 16'sd6434;
      1: base = 16'sd12868;
      2: base = 16'sd19302;
      default: base = 16'sd32170;
    endcase
    base = base + ang_t'($urandom_range(0, 3)) - 16'sd2;
    return ($urandom_range(0, 1) == 1) ? -base : base;
  endfunction

  function automatic pos_t near_position();
    return pos_t'($urandom_range(0, 2097151)) - 32'sd1048576;
  endfunction

  function automatic pose_pair_t random_pose_pair();
    pose_pair_t p;
    int         style;
    style = $urandom_range(0, 9);
    p.ref_present = (style == 8) ? ($urandom_range(0, 4) == 0) : 1'($urandom_range(0, 1));
    p.ref_x       = pos_t'($urandom);
    p.ref_y       = pos_t'($urandom);
    p.ref_heading = ang_t'($urandom);
    p.tgt_x       = pos_t'($urandom);
    p.tgt_y       = pos_t'($urandom);
    p.tgt_heading = ang_t'($urandom);
    case (style)
      4, 5: begin
        p.ref_x = near_position();
        p.ref_y = near_position();
        p.tgt_x = near_position();
        p.tgt_y = near_position();
      end
      6, 7: begin
        p.ref_heading = fold_heading();
        p.tgt_heading = fold_heading();
      end
      9: begin
        p.ref_x = edge_position();
        p.ref_y = edge_position();
        p.tgt_x = edge_position();
        p.tgt_y = edge_position();
      end
      default: ;
    endcase
    return p;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_pose_pair(input pose_pair_t p, input residual_t want,
                                input int gap);
    if (gap > 0) begin
      pose_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pose_bus.valid       <= 1'b1;
    pose_bus.ref_present <= p.ref_present;
    pose_bus.ref_x       <= p.ref_x;
    pose_bus.ref_y       <= p.ref_y;
    pose_bus.ref_heading <= p.ref_heading;
    pose_bus.tgt_x       <= p.tgt_x;
    pose_bus.tgt_y       <= p.tgt_y;
    pose_bus.tgt_heading <= p.tgt_heading;
    do @(posedge clk); while (!pose_bus.ready);
    pending_residuals.push_back(want);
    @(negedge clk);
  endtask

  task automatic drain_residuals();
    pose_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_residuals.size() != 0);
  endtask

  initial begin : pose_source
    vector_row_t row;
    pose_pair_t  p;
    residual_t   want;
    bit          steady;
    rst_n = 1'b0;
    pose_bus.valid = 1'b0;
    pose_bus.ref_present = 1'b0;
    pose_bus.ref_x = '0;
    pose_bus.ref_y = '0;
    pose_bus.ref_heading = '0;
    pose_bus.tgt_x = '0;
    pose_bus.tgt_y = '0;
    pose_bus.tgt_heading = '0;
    error_count = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      row = DIRECTED[k];
      p = '{row.present, row.rx, row.ry, row.rh, row.tx, row.ty, row.th};
      want = predict_residual(p);
      if (row.known_relh) want.rel_heading = row.relh;
      if (row.known_part) begin
        want.drelx_dheading = row.px;
        want.drely_dheading = row.py;
      end
      send_pose_pair(p, want, (k % 3 == 0) ? 0 : $urandom_range(0, MAX_WAIT));
    end
    drain_residuals();

    steady = 1'b0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_BEATS / 2) drain_residuals();
      p = random_pose_pair();
      send_pose_pair(p, predict_residual(p), steady ? 0 : $urandom_range(0, MAX_WAIT));
    end
    drain_residuals();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : residual_sink
    int stall;
    int beats;
    bit steady;
    residual_bus.ready = 1'b0;
    beats = 0;
    steady = 1'b0;
    do @(negedge clk); while (!rst_n);
    forever begin
      if (beats % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        residual_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      residual_bus.ready <= 1'b1;
      do @(posedge clk); while (!residual_bus.valid);
      beats++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    residual_t got;
    residual_t want;
    if (residual_bus.valid && residual_bus.ready) begin
      got = '{residual_bus.rel_x, residual_bus.rel_y, residual_bus.rel_heading,
              residual_bus.cos_ref, residual_bus.sin_ref,
              residual_bus.drelx_dheading, residual_bus.drely_dheading};
      if (pending_residuals.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected residual beat %0d at %0t", residual_beats, $realtime);
        error_count++;
      end else begin
        want = pending_residuals.pop_front();
        if (got.rel_x !== want.rel_x || got.rel_y !== want.rel_y ||
            got.rel_heading !== want.rel_heading || got.cos_ref !== want.cos_ref ||
            got.sin_ref !== want.sin_ref ||
            got.drelx_dheading !== want.drelx_dheading ||
            got.drely_dheading !== want.drely_dheading) begin
          if (error_count < MAX_REPORTS) begin
            $display("residual beat %0d mismatch (expected / actual):", residual_beats);
            $display("  rel_x %0d / %0d  rel_y %0d / %0d  rel_heading %0d / %0d",
                     want.rel_x, got.rel_x, want.rel_y, got.rel_y,
                     want.rel_heading, got.rel_heading);
            $display("  cos %0d / %0d  sin %0d / %0d", want.cos_ref, got.cos_ref,
                     want.sin_ref, got.sin_ref);
            $display("  drelx %0d / %0d  drely %0d / %0d",
                     want.drelx_dheading, got.drelx_dheading,
                     want.drely_dheading, got.drely_dheading);
          end
          error_count++;
        end
      end
      residual_beats++;
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((pose_bus.valid && pose_bus.ready) ||
        (residual_bus.valid && residual_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    residual_beats = 0;
    idle_cycles = 0;
  end

endmodule
